// ===== rtl/core/vru_pkg.sv =====
// Shared types and constants for the vector refraction unit.
package vru_pkg;

  localparam int VEC_W         = 32;
  localparam int ETA_W         = 20;
  localparam int ETA_FRAC      = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RAD_W         = 62;
  localparam int SQ_W          = RAD_W / 2;

  // Item fields that ride alongside the arithmetic through the pipeline
  typedef struct packed {
    logic [2:0][VEC_W-1:0] iv;
    logic [2:0][VEC_W-1:0] nv;
    logic [ETA_W-1:0]      eta;
    logic [VEC_W-1:0]      ed;
    logic                  sat;
    logic                  tir;
  } vru_side_t;

endpackage

// ===== rtl/core/vru_in_if.sv =====
// Input channel: incident vector, normal and index ratio.
interface vru_in_if import vru_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] inc_x;
  logic signed [VEC_W-1:0] inc_y;
  logic signed [VEC_W-1:0] inc_z;
  logic signed [VEC_W-1:0] nrm_x;
  logic signed [VEC_W-1:0] nrm_y;
  logic signed [VEC_W-1:0] nrm_z;
  logic [ETA_W-1:0]        index_ratio;

  modport source (output valid, inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, index_ratio,
                  input ready);
  modport sink   (input valid, inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, index_ratio,
                  output ready);
endinterface

// ===== rtl/core/vru_out_if.sv =====
// Output channel: refracted vector and status flags.
interface vru_out_if import vru_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] out_x;
  logic signed [VEC_W-1:0] out_y;
  logic signed [VEC_W-1:0] out_z;
  logic                    total_reflect;
  logic                    saturated;

  modport source (output valid, out_x, out_y, out_z, total_reflect, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, total_reflect, saturated,
                   output ready);
endinterface

// ===== rtl/core/vru_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module vru_sqrt_pipe import vru_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAD_W-1:0] rad,
  input  vru_side_t        side_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SQ_W-1:0]  root,
  output vru_side_t        side_out
);

  localparam int REM_W = SQ_W + 2;

  logic             v    [SQ_W];
  logic             ld   [SQ_W];
  logic [RAD_W-1:0] rads [SQ_W];
  logic [REM_W-1:0] rems [SQ_W];
  logic [SQ_W-1:0]  roots[SQ_W];
  vru_side_t        sides[SQ_W];

  // Stage j loads when empty or when its item moves on
  always_comb begin
    for (int j = SQ_W - 1; j >= 0; j--) begin
      if (j == SQ_W - 1) begin
        ld[j] = !v[j] || out_ready;
      end else begin
        ld[j] = !v[j] || ld[j+1];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v[SQ_W-1];
  assign root      = roots[SQ_W-1];
  assign side_out  = sides[SQ_W-1];

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < SQ_W; j++) v[j] <= 1'b0;
    end else begin
      for (int j = 0; j < SQ_W; j++) begin
        if (ld[j]) v[j] <= (j == 0) ? in_valid : v[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // One restoring step per stage
  always_ff @(posedge clk) begin
    logic [RAD_W-1:0] r_in;
    logic [REM_W-1:0] m_in;
    logic [SQ_W-1:0]  q_in;
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    for (int j = 0; j < SQ_W; j++) begin
      if (ld[j]) begin
        if (j == 0) begin
          r_in = rad;
          m_in = '0;
          q_in = '0;
          sides[j] <= side_in;
        end else begin
          r_in = rads[j-1];
          m_in = rems[j-1];
          q_in = roots[j-1];
          sides[j] <= sides[j-1];
        end
        rem2  = {m_in, r_in[RAD_W-1 -: 2]};
        trial = {1'b0, q_in, 2'b01};
        rads[j] <= {r_in[RAD_W-3:0], 2'b00};
        if (rem2 >= trial) begin
          rems[j]  <= REM_W'(rem2 - trial);
          roots[j] <= {q_in[SQ_W-2:0], 1'b1};
        end else begin
          rems[j]  <= REM_W'(rem2);
          roots[j] <= {q_in[SQ_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ===== rtl/core/vector_refraction_unit_core.sv =====
// Vector refraction unit: pipelined fixed-point GLSL refract on 3-vectors.
// Pipeline: 6 front stages + 31 square-root stages + 3 back stages.
// Throughput: one item per cycle while rsp.ready holds; the 31-stage square root
// (one bit a stage) sets the depth. Each stage holds its item when the next one is full.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module vector_refraction_unit_core import vru_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  vru_in_if.sink     req,
  vru_out_if.source  rsp
);

  localparam int EE_SH = 2 * ETA_FRAC - FRAC_BITS;
  localparam logic signed [65:0] ONE    = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] D_LIM  = 66'sd1 <<< 40;
  localparam logic signed [62:0] ED_LIM = 63'sd1 <<< 30;
  localparam logic signed [66:0] O_MAX  = 67'sd2147483647;
  localparam logic signed [66:0] O_MIN  = -67'sd2147483648;

  // valid bits and load enables
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ld9;
  logic sq_in_ready, sq_out_valid;

  vru_side_t s1, s2, s3, s4, s5, s6, sq_side, s7, s8;
  logic signed [63:0] p1 [3];
  logic signed [41:0] d2;
  logic [39:0]        ee2, ee3, ee4, ee5;
  logic signed [62:0] ped3;
  logic signed [63:0] edsq5;
  logic [RAD_W-1:0]   rad6;
  logic [SQ_W-1:0]    sq_root;
  logic signed [33:0] m7;
  logic signed [52:0] ie8 [3];
  logic signed [65:0] nm8 [3];
  logic signed [VEC_W-1:0] o9 [3];
  logic tir9, sat9;

  // Backpressure chain
  assign ld9 = !v9 || rsp.ready;
  assign ld8 = !v8 || ld9;
  assign ld7 = !v7 || ld8;
  assign ld6 = !v6 || sq_in_ready;
  assign ld5 = !v5 || ld6;
  assign ld4 = !v4 || ld5;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign req.ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else begin
      if (ld1) v1 <= req.valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ld6) v6 <= v5;
      if (ld7) v7 <= sq_out_valid;
      if (ld8) v8 <= v7;
      if (ld9) v9 <= v8;
    end
  end

  // Stage 1: component products N*I
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1.iv  <= {req.inc_z, req.inc_y, req.inc_x};
      s1.nv  <= {req.nrm_z, req.nrm_y, req.nrm_x};
      s1.eta <= req.index_ratio;
      s1.ed  <= '0;
      s1.sat <= 1'b0;
      s1.tir <= 1'b0;
      p1[0]  <= req.nrm_x * req.inc_x;
      p1[1]  <= req.nrm_y * req.inc_y;
      p1[2]  <= req.nrm_z * req.inc_z;
    end
  end

  // Stage 2: dot product sum and clamp, eta squared
  always_ff @(posedge clk) begin
    logic signed [65:0] a0, a1, a2, ds;
    if (ld2) begin
      a0 = p1[0] >>> FRAC_BITS;
      a1 = p1[1] >>> FRAC_BITS;
      a2 = p1[2] >>> FRAC_BITS;
      ds = a0 + a1 + a2;
      s2 <= s1;
      if (ds > D_LIM) begin
        d2 <= 42'(D_LIM);
        s2.sat <= 1'b1;
      end else if (ds < -D_LIM) begin
        d2 <= 42'(-D_LIM);
        s2.sat <= 1'b1;
      end else begin
        d2 <= 42'(ds);
      end
      ee2 <= 40'(s1.eta) * 40'(s1.eta);
    end
  end

  // Stage 3: eta * d
  always_ff @(posedge clk) begin
    if (ld3) begin
      s3   <= s2;
      ee3  <= ee2;
      ped3 <= $signed({1'b0, s2.eta}) * d2;
    end
  end

  // Stage 4: scale and clamp eta*d
  always_ff @(posedge clk) begin
    logic signed [62:0] edw;
    if (ld4) begin
      edw = ped3 >>> ETA_FRAC;
      s4  <= s3;
      ee4 <= ee3;
      if (edw > ED_LIM) begin
        s4.ed  <= VEC_W'(ED_LIM);
        s4.sat <= 1'b1;
      end else if (edw < -ED_LIM) begin
        s4.ed  <= VEC_W'(-ED_LIM);
        s4.sat <= 1'b1;
      end else begin
        s4.ed <= VEC_W'(edw);
      end
    end
  end

  // Stage 5: ed squared
  always_ff @(posedge clk) begin
    if (ld5) begin
      s5    <= s4;
      ee5   <= ee4;
      edsq5 <= $signed(s4.ed) * $signed(s4.ed);
    end
  end

  // Stage 6: k, reflection test, square root radicand
  always_ff @(posedge clk) begin
    logic signed [65:0] eet, eds, k;
    if (ld6) begin
      eet = $signed({26'd0, ee5 >> EE_SH});
      eds = edsq5 >>> FRAC_BITS;
      k   = ONE - eet + eds;
      s6  <= s5;
      s6.tir <= k[65];
      rad6 <= k[65] ? '0 : RAD_W'(k <<< FRAC_BITS);
    end
  end

  vru_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_ready  (sq_in_ready),
    .rad       (rad6),
    .side_in   (s6),
    .out_valid (sq_out_valid),
    .out_ready (ld7),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // Stage 7: m = ed + sqrt(k)
  always_ff @(posedge clk) begin
    if (ld7) begin
      s7 <= sq_side;
      m7 <= 34'($signed(sq_side.ed)) + $signed({3'b000, sq_root});
    end
  end

  // Stage 8: I*eta and N*m
  always_ff @(posedge clk) begin
    if (ld8) begin
      s8 <= s7;
      for (int c = 0; c < 3; c++) begin
        ie8[c] <= $signed(s7.iv[c]) * $signed({1'b0, s7.eta});
        nm8[c] <= $signed(s7.nv[c]) * m7;
      end
    end
  end

  // Stage 9: difference, output clamp, reflection override
  always_ff @(posedge clk) begin
    logic signed [66:0] a, b, dv;
    logic sat;
    if (ld9) begin
      sat = s8.sat;
      for (int c = 0; c < 3; c++) begin
        a  = ie8[c] >>> ETA_FRAC;
        b  = nm8[c] >>> FRAC_BITS;
        dv = a - b;
        if (s8.tir) begin
          o9[c] <= '0;
        end else if (dv > O_MAX) begin
          o9[c] <= VEC_W'(O_MAX);
          sat = 1'b1;
        end else if (dv < O_MIN) begin
          o9[c] <= VEC_W'(O_MIN);
          sat = 1'b1;
        end else begin
          o9[c] <= VEC_W'(dv);
        end
      end
      tir9 <= s8.tir;
      sat9 <= sat && !s8.tir;
    end
  end

  assign rsp.valid         = v9;
  assign rsp.out_x         = o9[0];
  assign rsp.out_y         = o9[1];
  assign rsp.out_z         = o9[2];
  assign rsp.total_reflect = tir9;
  assign rsp.saturated     = sat9;

endmodule

// ===== tb/tb_vector_refraction_unit_core.sv =====
// Testbench for vector_refraction_unit_core: random-stall stream with a scoreboard predictor.
`timescale 1ns / 1ps

module tb_vector_refraction_unit_core;
  import vru_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic signed [VEC_W-1:0] ix, iy, iz, nx, ny, nz;
    logic [ETA_W-1:0]        eta;
  } ray_t;

  typedef struct {
    logic signed [VEC_W-1:0] ox, oy, oz;
    logic                    tir;
    logic                    sat;
  } refr_t;

  // Refraction scoreboard: predicts each accepted ray, checks results in order
  class refract_board;
    refr_t pending_q[$];
    int    errors;
    int    n_rays;
    int    n_tir;
    int    n_sat;

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint clip(longint v, longint lo, longint hi, inout bit sat);
      if (v > hi) begin
        sat = 1;
        return hi;
      end
      if (v < lo) begin
        sat = 1;
        return lo;
      end
      return v;
    endfunction

    function refr_t refract(ray_t r);
      longint iv[3], nv[3];
      longint eta, d, ed, k, m, v;
      longint unsigned s;
      bit sat;
      refr_t o;
      iv[0] = r.ix; iv[1] = r.iy; iv[2] = r.iz;
      nv[0] = r.nx; nv[1] = r.ny; nv[2] = r.nz;
      eta = longint'(r.eta);
      sat = 0;
      d = 0;
      for (int c = 0; c < 3; c++) d += (nv[c] * iv[c]) >>> FB;
      d  = clip(d, -(64'sd1 <<< 40), 64'sd1 <<< 40, sat);
      ed = (eta * d) >>> ETA_FRAC;
      ed = clip(ed, -(64'sd1 <<< 30), 64'sd1 <<< 30, sat);
      k  = (64'sd1 <<< FB) - ((eta * eta) >>> (2 * ETA_FRAC - FB)) + ((ed * ed) >>> FB);
      if (k < 0) begin
        o.ox = 0; o.oy = 0; o.oz = 0;
        o.tir = 1;
        o.sat = 0;
        return o;
      end
      s = isqrt(longint'(k) << FB);
      m = ed + longint'(s);
      for (int c = 0; c < 3; c++) begin
        v = ((iv[c] * eta) >>> ETA_FRAC) - ((nv[c] * m) >>> FB);
        v = clip(v, -64'sd2147483648, 64'sd2147483647, sat);
        iv[c] = v;
      end
      o.ox = iv[0][31:0]; o.oy = iv[1][31:0]; o.oz = iv[2][31:0];
      o.tir = 0;
      o.sat = sat;
      return o;
    endfunction

    function void note_ray(ray_t r);
      refr_t o;
      o = refract(r);
      n_rays++;
      if (o.tir) n_tir++;
      if (o.sat) n_sat++;
      pending_q.push_back(o);
    endfunction

    function void check_result(refr_t got);
      refr_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time, got.ox, got.oy, got.oz);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.ox !== exp_r.ox) begin
        $display("%0t: out_x exp %h got %h", $time, exp_r.ox, got.ox);
        errors++;
      end
      if (got.oy !== exp_r.oy) begin
        $display("%0t: out_y exp %h got %h", $time, exp_r.oy, got.oy);
        errors++;
      end
      if (got.oz !== exp_r.oz) begin
        $display("%0t: out_z exp %h got %h", $time, exp_r.oz, got.oz);
        errors++;
      end
      if (got.tir !== exp_r.tir) begin
        $display("%0t: total_reflect exp %b got %b", $time, exp_r.tir, got.tir);
        errors++;
      end
      if (got.sat !== exp_r.sat) begin
        $display("%0t: saturated exp %b got %b", $time, exp_r.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;   // no idling on either side while set

  vru_in_if  req ();
  vru_out_if rsp ();

  vector_refraction_unit_core #(.FRAC_BITS(FB)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  refract_board board = new();

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sender: optional idle cycles, then hold the item until accepted
  task automatic send_ray(ray_t r);
    while (!steady && $urandom_range(0, 99) < 25) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.valid       <= 1'b1;
    req.inc_x       <= r.ix;
    req.inc_y       <= r.iy;
    req.inc_z       <= r.iz;
    req.nrm_x       <= r.nx;
    req.nrm_y       <= r.ny;
    req.nrm_z       <= r.nz;
    req.index_ratio <= r.eta;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_ray(r);
  endtask

  function automatic logic signed [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h3FFFF) - 32'sh20000;
      default: return $urandom_range(0, 32'h1FFFF) - 32'sh10000;
    endcase
  endfunction

  task automatic send_fill(logic signed [31:0] vi, logic signed [31:0] vn,
                           logic [19:0] eta);
    ray_t r;
    r.ix = vi; r.iy = vi; r.iz = vi;
    r.nx = vn; r.ny = vn; r.nz = vn;
    r.eta = eta;
    send_ray(r);
  endtask

  // Receiver: random back-pressure, compare at rising edge
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    refr_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.ox  = rsp.out_x;
      got.oy  = rsp.out_y;
      got.oz  = rsp.out_z;
      got.tir = rsp.total_reflect;
      got.sat = rsp.saturated;
      board.check_result(got);
    end
  end

  // Stimulus
  initial begin
    ray_t r;
    int   mode;
    rst             = 1'b1;
    steady          = 1'b0;
    req.valid       = 1'b0;
    req.inc_x       = '0;
    req.inc_y       = '0;
    req.inc_z       = '0;
    req.nrm_x       = '0;
    req.nrm_y       = '0;
    req.nrm_z       = '0;
    req.index_ratio = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, zero eta, total reflection, internal and output clamps
    send_fill(0, 0, 0);
    send_fill(32'sh7FFFFFFF, 32'sh7FFFFFFF, 20'hFFFFF);
    send_fill(32'sh80000000, 32'sh80000000, 20'hFFFFF);
    send_fill(32'sh7FFFFFFF, 32'sh80000000, 20'hFFFFF);
    send_fill(32'sh80000000, 32'sh7FFFFFFF, 0);
    send_fill(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    send_fill(32'sh10000, 32'sh10000, 20'h10000);
    send_fill(-32'sh10000, 32'sh10000, 20'h08000);
    send_fill(32'sh20000000, 32'sh00010000, 20'h10000);
    send_fill(-1, -1, 20'h00001);
    send_fill(32'sh00001000, 32'sh00010000, 20'h30000);
    r = '{ix: 32'sh10000, iy: 0, iz: 0, nx: 0, ny: 32'sh10000, nz: 0, eta: 20'h20000};
    send_ray(r);   // grazing ray, large eta: total reflection
    r = '{ix: 32'sh10000, iy: 0, iz: 0, nx: 0, ny: 32'sh10000, nz: 0, eta: 20'h10000};
    send_ray(r);   // k exactly zero
    r = '{ix: 32'sh0B505, iy: -32'sh0B505, iz: 0, nx: 0, ny: 32'sh10000, nz: 0,
          eta: 20'h0AAAB};
    send_ray(r);
    r = '{ix: 32'sh7FFFFFFF, iy: 32'sh80000000, iz: 32'sh55555555,
          nx: 32'shAAAAAAAA, ny: 32'sh7FFFFFFF, nz: 32'sh80000000, eta: 20'hAAAAA};
    send_ray(r);
    r = '{ix: 32'sh55555555, iy: 32'shAAAAAAAA, iz: 0,
          nx: 32'sh55555555, ny: 32'shAAAAAAAA, nz: 32'sh7FFFFFFF, eta: 20'h55555};
    send_ray(r);

    // Random: mostly near-unit vectors with realistic eta, some wide noise
    for (int i = 0; i < 1150; i++) begin
      steady = (i >= 400 && i < 600);
      mode = $urandom_range(0, 9);
      mode = (mode < 2) ? 0 : (mode < 4) ? 1 : 2;
      r.ix = rand_comp(mode); r.iy = rand_comp(mode); r.iz = rand_comp(mode);
      r.nx = rand_comp(mode); r.ny = rand_comp(mode); r.nz = rand_comp(mode);
      if ($urandom_range(0, 3) == 0) r.eta = ETA_W'($urandom_range(0, 20'hFFFFF));
      else r.eta = ETA_W'($urandom_range(20'h04000, 20'h28000));
      send_ray(r);
    end
    steady = 1'b0;
    @(negedge clk);
    req.valid <= 1'b0;

    // Drain, then allow the pipeline depth for stray results
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Rays checked: %0d, total reflections: %0d, saturated results: %0d",
             board.n_rays, board.n_tir, board.n_sat);
    $display("Random stalls on both channels with a stall-free middle stretch");
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
